[hw/rtl/afu_pkg.sv]
// Package for the 8085 arithmetic and flags unit: request, response and flag types,
// and the operation codes.
// Has no dependencies; every other file of the unit refers to it by scoped names.
`default_nettype none

package afu_pkg;

    // Operation codes carried in the func field of a request.
    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_ADC = 4'd1;
    localparam logic [3:0] FN_SUB = 4'd2;
    localparam logic [3:0] FN_SBB = 4'd3;
    localparam logic [3:0] FN_INR = 4'd4;
    localparam logic [3:0] FN_DCR = 4'd5;
    localparam logic [3:0] FN_INX = 4'd6;
    localparam logic [3:0] FN_DCX = 4'd7;
    localparam logic [3:0] FN_DAD = 4'd8;
    localparam logic [3:0] FN_DAA = 4'd9;

    // Decimal adjust thresholds and corrections.
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [7:0] DAA_LO_CORR  = 8'h06;
    localparam logic [7:0] DAA_HI_CORR  = 8'h60;

    // Condition flags kept between requests.
    typedef struct packed {
        logic s;
        logic z;
        logic ac;
        logic p;
        logic cy;
    } flags_t;

    // One request.
    typedef struct packed {
        logic [3:0]  func;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [15:0] pair_value;
        logic [15:0] hl_value;
    } req_t;

    // One response.
    typedef struct packed {
        logic [7:0]  result_byte;
        logic [15:0] result_word;
        logic        sign_flag;
        logic        zero_flag;
        logic        aux_carry_flag;
        logic        parity_flag;
        logic        carry_flag;
    } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/afu_alu.sv]
// Combinational datapath of the 8085 arithmetic unit: byte adder with flag logic,
// decimal adjust correction and the 16-bit pair adder.
// Depends on afu_pkg.
`default_nettype none

module afu_alu (
    input  wire afu_pkg::req_t   req,
    input  wire afu_pkg::flags_t flags,
    output afu_pkg::rsp_t        rsp,
    output afu_pkg::flags_t      flags_next
);

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic        add_cin;
    logic [8:0]  byte_sum;
    logic [4:0]  nib_sum;
    logic        daa_lo;
    logic        daa_hi;
    logic [7:0]  daa_corr;
    logic [16:0] word_sum;
    logic [15:0] word_b;
    logic        byte_op;
    logic        word_op;
    logic        szp_valid;
    logic        cy_new;
    logic        ac_new;

    // Decimal adjust correction, taken from the kept flags.
    always_comb
    begin
        daa_lo   = (req.acc[3:0] > afu_pkg::DAA_LO_LIMIT) || flags.ac;
        daa_hi   = (req.acc > afu_pkg::DAA_HI_LIMIT) || flags.cy;
        daa_corr = (daa_lo ? afu_pkg::DAA_LO_CORR : 8'h00)
                 | (daa_hi ? afu_pkg::DAA_HI_CORR : 8'h00);
    end

    // Operand selection for the shared byte adder.
    always_comb
    begin
        add_a   = req.acc;
        add_b   = req.operand;
        add_cin = 1'b0;
        unique case (req.func)
            afu_pkg::FN_ADD:
            begin
                add_b = req.operand;
            end
            afu_pkg::FN_ADC:
            begin
                add_cin = flags.cy;
            end
            afu_pkg::FN_SUB:
            begin
                add_b   = ~req.operand;
                add_cin = 1'b1;
            end
            afu_pkg::FN_SBB:
            begin
                add_b   = ~req.operand;
                add_cin = ~flags.cy;
            end
            afu_pkg::FN_INR:
            begin
                add_a = req.operand;
                add_b = 8'h01;
            end
            afu_pkg::FN_DCR:
            begin
                add_a = req.operand;
                add_b = 8'hff;
            end
            afu_pkg::FN_DAA:
            begin
                add_b = daa_corr;
            end
            default:
            begin
                add_cin = 1'b0;
            end
        endcase
    end

    // Byte adder and carry out of the low nibble.
    assign byte_sum = {1'b0, add_a} + {1'b0, add_b} + {8'h00, add_cin};
    assign nib_sum  = {1'b0, add_a[3:0]} + {1'b0, add_b[3:0]} + {4'h0, add_cin};
    assign ac_new   = nib_sum[4];

    // Pair adder: increment, decrement or HL plus pair.
    always_comb
    begin
        word_b = 16'h0000;
        case (req.func)
            afu_pkg::FN_INX: word_b = 16'h0001;
            afu_pkg::FN_DCX: word_b = 16'hffff;
            afu_pkg::FN_DAD: word_b = req.hl_value;
            default:         word_b = 16'h0000;
        endcase
    end

    assign word_sum = {1'b0, req.pair_value} + {1'b0, word_b};

    // Which results and flags each operation produces.
    always_comb
    begin
        byte_op   = 1'b0;
        word_op   = 1'b0;
        szp_valid = 1'b0;
        cy_new    = flags.cy;
        unique case (req.func)
            afu_pkg::FN_ADD, afu_pkg::FN_ADC:
            begin
                byte_op   = 1'b1;
                szp_valid = 1'b1;
                cy_new    = byte_sum[8];
            end
            afu_pkg::FN_SUB, afu_pkg::FN_SBB:
            begin
                byte_op   = 1'b1;
                szp_valid = 1'b1;
                cy_new    = ~byte_sum[8];
            end
            afu_pkg::FN_INR, afu_pkg::FN_DCR:
            begin
                byte_op   = 1'b1;
                szp_valid = 1'b1;
            end
            afu_pkg::FN_INX, afu_pkg::FN_DCX:
            begin
                word_op = 1'b1;
            end
            afu_pkg::FN_DAD:
            begin
                word_op = 1'b1;
                cy_new  = word_sum[16];
            end
            afu_pkg::FN_DAA:
            begin
                byte_op   = 1'b1;
                szp_valid = 1'b1;
                cy_new    = byte_sum[8] | daa_hi;
            end
            default:
            begin
                cy_new = flags.cy;
            end
        endcase
    end

    // New flag set; operations that do not touch a flag pass the kept value on.
    always_comb
    begin
        flags_next    = flags;
        flags_next.cy = cy_new;
        if (szp_valid)
        begin
            flags_next.s  = byte_sum[7];
            flags_next.z  = (byte_sum[7:0] == 8'h00);
            flags_next.ac = ac_new;
            flags_next.p  = ~(^byte_sum[7:0]);
        end
    end

    // Response fields.
    always_comb
    begin
        rsp.result_byte    = byte_op ? byte_sum[7:0] : 8'h00;
        rsp.result_word    = word_op ? word_sum[15:0] : 16'h0000;
        rsp.sign_flag      = flags_next.s;
        rsp.zero_flag      = flags_next.z;
        rsp.aux_carry_flag = flags_next.ac;
        rsp.parity_flag    = flags_next.p;
        rsp.carry_flag     = flags_next.cy;
    end

endmodule

`default_nettype wire

[hw/rtl/cpu8085_arith_flags_unit.sv]
// A request accepted into the input register moves on to the response register
// (input register, then response register); throughput is one request per cycle while rsp_stall is low.
// The kept flags are written as a request moves into the response register, so the
// next request in the input register already sees them.
// Reset clears the flags and both valid bits; payload registers are not reset.
`default_nettype none

module cpu8085_arith_flags_unit (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                req_valid,
    output logic               req_stall,
    input  wire afu_pkg::req_t req,
    output logic               rsp_valid,
    input  wire                rsp_stall,
    output afu_pkg::rsp_t      rsp
);

    logic             in_valid_reg;
    logic             in_valid_next;
    afu_pkg::req_t    in_req_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    afu_pkg::rsp_t    out_rsp_reg;
    afu_pkg::flags_t  flags_reg;
    afu_pkg::flags_t  flags_next;
    afu_pkg::rsp_t    alu_rsp;
    logic             advance;
    logic             in_load;

    // Datapath between the two registers.
    afu_alu u_alu (
        .req        (in_req_reg),
        .flags      (flags_reg),
        .rsp        (alu_rsp),
        .flags_next (flags_next)
    );

    // Handshake control: the input stage moves on when the response register is
    // empty or being emptied this cycle.
    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || !rsp_stall);
        req_stall      = in_valid_reg && !advance;
        in_load        = req_valid && !req_stall;
        in_valid_next  = in_load || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && rsp_stall);
    end

    // Control state and kept flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_req_reg <= req;
        end
        if (advance)
        begin
            out_rsp_reg <= alu_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

`ifndef SYNTHESIS
    // The kept flags always match the flags of the response just loaded.
    a_flags_follow_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (flags_reg == {rsp.sign_flag, rsp.zero_flag, rsp.aux_carry_flag,
                                   rsp.parity_flag, rsp.carry_flag}))
        else $error("kept flags differ from the last response");

    // Requests are only held off while the input register is occupied.
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> in_valid_reg)
        else $error("request stalled with an empty input register");

    // A request that cannot advance stays in the input register unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_req_reg)))
        else $error("held request lost or changed");
`endif

endmodule

`default_nettype wire
